[src/pcsc_pkg.sv]
// Shared types, codes and helper functions for the PCM integer sample converter.
// Used by every module of the block; depends on nothing.
package pcsc_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SampleW = 32;
  localparam int unsigned BitsW   = 6;
  localparam int unsigned CfgIdxW = 2;

  // Operation codes carried by the func field.
  localparam logic FUNC_UNPACK = 1'b0;
  localparam logic FUNC_PACK   = 1'b1;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_SAMPLE_BITS = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_IS_SIGNED   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_LSB_FIRST   = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_SCALE_MODE  = 2'd3;

  // Container size, stored as the index of its last byte.
  localparam logic [1:0] LAST_IDX_1B = 2'd0;
  localparam logic [1:0] LAST_IDX_2B = 2'd1;
  localparam logic [1:0] LAST_IDX_4B = 2'd3;

  typedef struct packed {
    logic [BitsW-1:0] sample_bits;
    logic             is_signed;
    logic             lsb_first;
    logic             scale_mode;
  } pcsc_cfg_t;

  // One queued job: a finished sample, or a packed value to serialize.
  typedef struct packed {
    logic               is_pack;
    logic [SampleW-1:0] data;
    logic [1:0]         last_idx;
    logic               lsb_first;
  } pcsc_entry_t;

  // Sample width clamped to the range 1..32.
  function automatic logic [BitsW-1:0] eff_bits(logic [BitsW-1:0] sb);
    logic [BitsW-1:0] r;
    if (sb == '0) begin
      r = BitsW'(1);
    end else if (sb > BitsW'(SampleW)) begin
      r = BitsW'(SampleW);
    end else begin
      r = sb;
    end
    return r;
  endfunction

  function automatic logic [1:0] container_last(logic [BitsW-1:0] eb);
    logic [1:0] r;
    if (eb <= BitsW'(8)) begin
      r = LAST_IDX_1B;
    end else if (eb <= BitsW'(16)) begin
      r = LAST_IDX_2B;
    end else begin
      r = LAST_IDX_4B;
    end
    return r;
  endfunction

endpackage

[src/pcsc_front.sv]
// Front end: accepts input transactions, gathers stream bytes and forms queue jobs.
// Depends on pcsc_pkg; feeds pcsc_queue.
module pcsc_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pcsc_pkg::pcsc_cfg_t                 cfg_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                func_i,
  input  logic [pcsc_pkg::ByteW-1:0]          byte_in_i,
  input  logic signed [pcsc_pkg::SampleW-1:0] sample_in_i,
  input  logic                                q_full_i,
  output logic                                push_o,
  output pcsc_pkg::pcsc_entry_t               entry_o
);
  import pcsc_pkg::*;

  logic [SampleW-1:0] acc_q, acc_d;
  logic [1:0]         gath_q, gath_d;

  logic [BitsW-1:0]   eff;
  logic [1:0]         last_idx;
  logic [4:0]         shift;
  logic [SampleW-1:0] flip;
  logic [SampleW-1:0] acc_next;
  logic [2:0]         count;
  logic               done;
  logic               accept;
  logic [SampleW-1:0] raw;
  logic [SampleW-1:0] swapped;
  logic [SampleW-1:0] ordered;
  logic [SampleW-1:0] unscaled;
  logic [SampleW-1:0] unpack_val;
  logic [SampleW-1:0] src;
  logic [SampleW-1:0] pack_val;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    eff      = eff_bits(cfg_i.sample_bits);
    last_idx = container_last(eff);
    shift    = 5'(BitsW'(SampleW) - eff);
    flip     = cfg_i.is_signed ? '0 : {1'b1, {(SampleW-1){1'b0}}};
    acc_next = {acc_q[SampleW-ByteW-1:0], byte_in_i};
    count    = {1'b0, gath_q} + 3'd1;
    done     = count > {1'b0, last_idx};

    // The most recent container bytes, in arrival order and then byte-swapped.
    case (last_idx)
      LAST_IDX_1B: begin
        raw     = {24'b0, acc_next[7:0]};
        swapped = raw;
      end
      LAST_IDX_2B: begin
        raw     = {16'b0, acc_next[15:0]};
        swapped = {16'b0, acc_next[7:0], acc_next[15:8]};
      end
      default: begin
        raw     = acc_next;
        swapped = {acc_next[7:0], acc_next[15:8], acc_next[23:16], acc_next[31:24]};
      end
    endcase
    ordered = cfg_i.lsb_first ? swapped : raw;

    if (cfg_i.is_signed) begin
      case (last_idx)
        LAST_IDX_1B: unscaled = {{24{ordered[7]}}, ordered[7:0]};
        LAST_IDX_2B: unscaled = {{16{ordered[15]}}, ordered[15:0]};
        default:     unscaled = ordered;
      endcase
    end else begin
      unscaled = ordered;
    end

    unpack_val = cfg_i.scale_mode ? ((ordered << shift) ^ flip) : unscaled;
    src        = sample_in_i;
    pack_val   = cfg_i.scale_mode ? ((src ^ flip) >> shift) : src;
  end

  assign push_o             = accept && ((func_i == FUNC_PACK) || done);
  assign entry_o.is_pack    = (func_i == FUNC_PACK);
  assign entry_o.data       = (func_i == FUNC_PACK) ? pack_val : unpack_val;
  assign entry_o.last_idx   = last_idx;
  assign entry_o.lsb_first  = cfg_i.lsb_first;

  always_comb begin
    acc_d  = acc_q;
    gath_d = gath_q;
    if (accept && (func_i == FUNC_UNPACK)) begin
      if (done) begin
        acc_d  = '0;
        gath_d = '0;
      end else begin
        acc_d  = acc_next;
        gath_d = count[1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      gath_q <= '0;
    end else begin
      acc_q  <= acc_d;
      gath_q <= gath_d;
    end
  end

endmodule

[src/pcsc_queue.sv]
// Short job queue between the front end and the output serializer.
// Depends on pcsc_pkg for the entry type.
module pcsc_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  pcsc_pkg::pcsc_entry_t entry_i,
  output logic                  full_o,
  output logic                  valid_o,
  output pcsc_pkg::pcsc_entry_t head_o,
  input  logic                  pop_i
);
  import pcsc_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);

  pcsc_entry_t         mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef SYNTH
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue written while full");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> valid_o) else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth)) else $error("queue count out of range");
  a_fill_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i && (count_q == CntW'(Depth - 1))) |=> full_o)
    else $error("queue did not report full after last slot filled");
`endif

endmodule

[src/pcsc_back.sv]
// Back end: takes queue jobs and drives result transactions from an output register.
// Depends on pcsc_pkg; pops pcsc_queue.
module pcsc_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_valid_i,
  input  pcsc_pkg::pcsc_entry_t                q_head_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 is_byte_o,
  output logic signed [pcsc_pkg::SampleW-1:0]  sample_out_o,
  output logic [pcsc_pkg::ByteW-1:0]           byte_out_o,
  output logic                                 last_o
);
  import pcsc_pkg::*;

  logic               out_valid_q, out_valid_d;
  logic               is_byte_q, is_byte_d;
  logic [SampleW-1:0] sample_q, sample_d;
  logic [ByteW-1:0]   byte_q, byte_d;
  logic               last_q, last_d;
  logic [1:0]         k_q, k_d;

  logic               load;
  logic               k_last;
  logic [1:0]         pos;
  logic [SampleW-1:0] shifted;

  assign load   = q_valid_i && (!out_valid_q || !out_stall_i);
  assign k_last = (k_q == q_head_i.last_idx);
  assign pos    = q_head_i.lsb_first ? k_q : (q_head_i.last_idx - k_q);
  assign shifted = q_head_i.data >> {pos, 3'b000};

  always_comb begin
    out_valid_d = out_valid_q;
    is_byte_d   = is_byte_q;
    sample_d    = sample_q;
    byte_d      = byte_q;
    last_d      = last_q;
    k_d         = k_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = 1'b1;
      if (q_head_i.is_pack) begin
        is_byte_d = 1'b1;
        sample_d  = '0;
        byte_d    = shifted[ByteW-1:0];
        last_d    = k_last;
        k_d       = k_last ? 2'd0 : k_q + 2'd1;
        pop_o     = k_last;
      end else begin
        is_byte_d = 1'b0;
        sample_d  = q_head_i.data;
        byte_d    = '0;
        last_d    = 1'b1;
        pop_o     = 1'b1;
      end
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      k_q         <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    is_byte_q <= is_byte_d;
    sample_q  <= sample_d;
    byte_q    <= byte_d;
    last_q    <= last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign is_byte_o    = is_byte_q;
  assign sample_out_o = sample_q;
  assign byte_out_o   = byte_q;
  assign last_o       = last_q;

`ifndef SYNTH
  a_byte_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (k_q != 2'd0) |-> (q_valid_i && q_head_i.is_pack && (k_q <= q_head_i.last_idx)))
    else $error("byte index active without a pack job at the queue head");
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !pop_o)
    else $error("job retired while the output register was stalled");
  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (out_valid_q && last_q))
    else $error("job retired without a final result");
`endif

endmodule

[src/pcm_int_sample_converter_unit.sv]
// PCM integer sample converter: unpack from stream bytes, pack to stream bytes.
// Path: a job is written into the job queue, then loaded into the output register.
// Throughput: one input transaction per cycle while in_stall_o is low; a pack transaction
// yields one output byte per container byte (1, 2 or 4 bytes), from the byte serializer.
// Reset: configuration returns to 16-bit signed little-endian scaled; gather state,
// job queue and output register are cleared at once, with no clearing pass.
module pcm_int_sample_converter_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pcsc_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [pcsc_pkg::BitsW-1:0]           cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 func_i,
  input  logic [pcsc_pkg::ByteW-1:0]           byte_in_i,
  input  logic signed [pcsc_pkg::SampleW-1:0]  sample_in_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 is_byte_o,
  output logic signed [pcsc_pkg::SampleW-1:0]  sample_out_o,
  output logic [pcsc_pkg::ByteW-1:0]           byte_out_o,
  output logic                                 last_o
);
  import pcsc_pkg::*;

  pcsc_cfg_t   cfg_q, cfg_d;
  logic        q_full;
  logic        q_valid;
  logic        push;
  logic        pop;
  pcsc_entry_t push_entry;
  pcsc_entry_t head_entry;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_SAMPLE_BITS: cfg_d.sample_bits = cfg_data_i;
        REG_IS_SIGNED:   cfg_d.is_signed   = cfg_data_i[0];
        REG_LSB_FIRST:   cfg_d.lsb_first   = cfg_data_i[0];
        REG_SCALE_MODE:  cfg_d.scale_mode  = cfg_data_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_bits <= BitsW'(16);
      cfg_q.is_signed   <= 1'b1;
      cfg_q.lsb_first   <= 1'b1;
      cfg_q.scale_mode  <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pcsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .byte_in_i   (byte_in_i),
    .sample_in_i (sample_in_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  pcsc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (head_entry),
    .pop_i   (pop)
  );

  pcsc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (q_valid),
    .q_head_i     (head_entry),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .is_byte_o    (is_byte_o),
    .sample_out_o (sample_out_o),
    .byte_out_o   (byte_out_o),
    .last_o       (last_o)
  );

endmodule
